### hdl/totp_hmac_sha1_code_assert.svh
// Assertion macros for the TOTP code generator checker.
`ifndef TOTP_HMAC_SHA1_CODE_ASSERT_SVH
`define TOTP_HMAC_SHA1_CODE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TOTP_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define TOTP_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/totp_pkg.sv
// Types and constants shared by the TOTP code generator.
package totp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_TRUNC,
    ST_MOD,
    ST_DONE
  } totp_state_e;

  localparam int unsigned KeyRegs = 8;
  localparam logic [31:0] OtpMod = 32'd1000000;

  // Reciprocal of OtpMod scaled by 2^OtpShift, rounded up; exact for 31-bit operands.
  localparam logic [31:0] OtpRecip = 32'd2251799814;
  localparam int unsigned OtpShift = 51;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) k = 32'h5A827999;
    else if (rnd < 7'd40) k = 32'h6ED9EBA1;
    else if (rnd < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

### hdl/totp_hmac_sha1_code.sv
// TOTP six-digit code generator: HMAC-SHA1 over a 64-bit counter, truncated.
// Sequence: four SHA-1 compressions, each a block load, the rounds and a chaining add,
// then truncate, quotient and output load, after which out_valid_o rises.
// One counter at a time: input reopens once the code enters the output
// register, and a finished code waits only while the previous one is still unaccepted.
// Reset (async, active low) clears the key registers, sequencer and output valid.
module totp_hmac_sha1_code
  import totp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] time_step_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [19:0] otp_code_o
);

  // Key registers; index width covers exactly the eight registers.
  logic [63:0] key_q [KeyRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyRegs; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  totp_state_e state_q, state_d;
  logic [1:0]   blk_q, blk_d;      // which of the four compressions
  logic [6:0]   rnd_q, rnd_d;      // load word / round counter
  logic [63:0]  msg_q;             // captured counter
  logic [31:0]  w_q [16];          // schedule window
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  h_q [5];           // running chaining value
  logic [159:0] inner_q;           // inner digest
  logic [31:0]  rem_q;             // truncated value under reduction
  logic [11:0]  quo_q;             // quotient by OtpMod
  logic [19:0]  code_q;
  logic         out_valid_q;
  logic         out_load;          // finished code moves into the output register

  // Current 32-bit block word for load phase.
  logic [31:0] blk_word;
  logic [3:0]  widx;
  logic [63:0] kreg;
  logic [7:0]  pad_byte;

  assign widx     = rnd_q[3:0];
  assign kreg     = key_q[widx[3:1]];
  assign pad_byte = blk_q[1] ? OpadByte : IpadByte;

  always_comb begin
    blk_word = '0;
    case (blk_q)
      2'd0, 2'd2: begin
        blk_word = (widx[0] ? kreg[31:0] : kreg[63:32]) ^ {4{pad_byte}};
      end
      2'd1: begin
        case (widx)
          4'd0:  blk_word = msg_q[63:32];
          4'd1:  blk_word = msg_q[31:0];
          4'd2:  blk_word = 32'h80000000;
          4'd15: blk_word = 32'd576;
          default: blk_word = '0;
        endcase
      end
      default: begin
        case (widx)
          4'd0:  blk_word = inner_q[159:128];
          4'd1:  blk_word = inner_q[127:96];
          4'd2:  blk_word = inner_q[95:64];
          4'd3:  blk_word = inner_q[63:32];
          4'd4:  blk_word = inner_q[31:0];
          4'd5:  blk_word = 32'h80000000;
          4'd15: blk_word = 32'd672;
          default: blk_word = '0;
        endcase
      end
    endcase
  end

  // Shared round unit.
  logic [31:0] wcur, wnew, wmix, tsum;
  logic [3:0]  ri;
  assign ri   = rnd_q[3:0];
  assign wmix = w_q[ri + 4'd13] ^ w_q[ri + 4'd8] ^ w_q[ri + 4'd2] ^ w_q[ri];
  assign wnew = {wmix[30:0], wmix[31]};
  assign wcur = (rnd_q < 7'd16) ? w_q[ri] : wnew;
  assign tsum = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
                + round_k(rnd_q) + wcur;

  // Truncation from the final digest (h_q after last add).
  logic [159:0] mac;
  logic [3:0]   off;
  logic [31:0]  trunc;
  assign mac   = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
  assign off   = mac[3:0];
  always_comb begin
    trunc = mac[159 - {off, 3'b000} -: 32];
    trunc[31] = 1'b0;
  end

  // Reduction: quotient by reciprocal multiply registered in ST_MOD, remainder formed from it in ST_DONE.
  logic [63:0] recip_prod;
  logic [31:0] qmul;
  logic [31:0] rem_next;
  assign recip_prod = {32'd0, rem_q} * {32'd0, OtpRecip};
  assign qmul       = {20'd0, quo_q} * OtpMod;
  assign rem_next   = rem_q - qmul;

  // Load the code when the output register is empty or being drained this cycle.
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    blk_d   = blk_q;
    rnd_d   = rnd_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOAD;
          blk_d   = 2'd0;
          rnd_d   = '0;
        end
      end
      ST_LOAD: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'd15) begin
          state_d = ST_ROUND;
          rnd_d   = '0;
        end
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'd79) state_d = ST_ADD;
      end
      ST_ADD: begin
        rnd_d   = '0;
        blk_d   = blk_q + 2'd1;
        state_d = (blk_q == 2'd3) ? ST_TRUNC : ST_LOAD;
      end
      ST_TRUNC: state_d = ST_MOD;
      ST_MOD:   state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      blk_q   <= '0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
      rnd_q   <= rnd_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) msg_q <= time_step_i;
      end
      ST_LOAD: begin
        w_q[widx] <= blk_word;
        if (rnd_q == 7'd0 && (blk_q == 2'd0 || blk_q == 2'd2)) begin
          h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
        end
        if (rnd_q == 7'd15) begin
          if (blk_q == 2'd0 || blk_q == 2'd2) begin
            a_q <= H0; b_q <= H1; c_q <= H2; d_q <= H3; e_q <= H4;
          end else begin
            a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
          end
        end
      end
      ST_ROUND: begin
        w_q[ri] <= wcur;
        e_q <= d_q;
        d_q <= c_q;
        c_q <= {b_q[1:0], b_q[31:2]};
        b_q <= a_q;
        a_q <= tsum;
      end
      ST_ADD: begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
        if (blk_q == 2'd1) begin
          inner_q <= {h_q[0] + a_q, h_q[1] + b_q, h_q[2] + c_q, h_q[3] + d_q, h_q[4] + e_q};
        end
      end
      ST_TRUNC: begin
        rem_q <= trunc;
      end
      ST_MOD: begin
        quo_q <= recip_prod[OtpShift +: 12];
      end
      default: ;
    endcase
  end

  // Output register: load the finished code, drop valid on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) code_q <= rem_next[19:0];
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign otp_code_o  = code_q;

endmodule

### hdl/totp_chk.sv
// Port-level checker for the TOTP code generator, bound to the top level.
`include "totp_hmac_sha1_code_assert.svh"
module totp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [19:0] otp_code_o
);
  `TOTP_ASSERT_IMP(code_range, clk_i, rst_ni, out_valid_o, otp_code_o < 20'd1000000)
  `TOTP_ASSERT_NXT(busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `TOTP_ASSERT_NXT(result_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(otp_code_o))
endmodule

bind totp_hmac_sha1_code totp_chk u_totp_chk (.*);
